// File: rtl/pfi_pkg.sv
package pfi_pkg;

	localparam int DATA_W    = 32;
	localparam int REACH_W   = 31;
	localparam int KIND_W    = 3;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CMD_DEPTH = 2;
	localparam int RES_DEPTH = 2;

	localparam logic [CFG_W-1:0] DAMP_RESET   = 16'd7864;
	localparam logic [CFG_W-1:0] WALL_W_RESET = 16'd1024;
	localparam logic [CFG_W-1:0] WALL_H_RESET = 16'd768;
	// 0.3 in unsigned q0.16
	localparam logic [CFG_W-1:0] BOUNCE_GAIN  = 16'd19661;

	localparam logic [CFG_IDX_W-1:0] REG_DAMP   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WALL_W = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WALL_H = 2'd2;

	localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

	typedef enum logic [KIND_W-1:0] {
		OP_LOAD    = 3'd0,
		OP_CLEAR   = 3'd1,
		OP_ADD     = 3'd2,
		OP_REPEL   = 3'd3,
		OP_ATTRACT = 3'd4,
		OP_DAMP    = 3'd5,
		OP_UPDATE  = 3'd6,
		OP_NONE    = 3'd7
	} op_t;

	typedef struct packed {
		op_t                        op;
		logic signed [DATA_W-1:0]   ax;
		logic signed [DATA_W-1:0]   ay;
		logic signed [DATA_W-1:0]   lvx;
		logic signed [DATA_W-1:0]   lvy;
		logic [REACH_W-1:0]         reach;
		logic signed [DATA_W-1:0]   strength;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] px;
		logic signed [DATA_W-1:0] py;
		logic signed [DATA_W-1:0] vx;
		logic signed [DATA_W-1:0] vy;
		logic signed [DATA_W-1:0] dfx;
		logic signed [DATA_W-1:0] dfy;
		logic                     hit;
	} res_t;

	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [31:0] den;
	} div_req_t;

	// saturate a 33-bit sum to 32 bits
	function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
		logic signed [DATA_W-1:0] r;
		if (v[DATA_W] != v[DATA_W-1]) begin
			r = v[DATA_W] ? S32_MIN : S32_MAX;
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

	// saturating negate
	function automatic logic signed [DATA_W-1:0] neg32(input logic signed [DATA_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v == S32_MIN) begin
			r = S32_MAX;
		end else begin
			r = -v;
		end
		return r;
	endfunction

	// magnitude of a signed 32-bit value
	function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
		logic [DATA_W-1:0] r;
		r = v[DATA_W-1] ? (~v + 32'd1) : v;
		return r;
	endfunction

endpackage

// File: rtl/pfi_fifo.sv
module pfi_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         full,
	output logic         empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/pfi_front.sv
module pfi_front #(
	parameter int DEPTH = 2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [pfi_pkg::KIND_W-1:0]       kind,
	input  logic signed [pfi_pkg::DATA_W-1:0] arg_x,
	input  logic signed [pfi_pkg::DATA_W-1:0] arg_y,
	input  logic signed [pfi_pkg::DATA_W-1:0] load_vel_x,
	input  logic signed [pfi_pkg::DATA_W-1:0] load_vel_y,
	input  logic [pfi_pkg::REACH_W-1:0]      reach,
	input  logic signed [pfi_pkg::DATA_W-1:0] strength,
	input  logic                             cmd_pop,
	output logic                             cmd_valid,
	output pfi_pkg::cmd_t                    cmd
);
	import pfi_pkg::*;

	cmd_t cmd_in;
	logic cmd_empty;

	// classify the item kind into an operation code
	always_comb begin
		cmd_in.ax       = arg_x;
		cmd_in.ay       = arg_y;
		cmd_in.lvx      = load_vel_x;
		cmd_in.lvy      = load_vel_y;
		cmd_in.reach    = reach;
		cmd_in.strength = strength;
		case (kind)
			OP_LOAD:    cmd_in.op = OP_LOAD;
			OP_CLEAR:   cmd_in.op = OP_CLEAR;
			OP_ADD:     cmd_in.op = OP_ADD;
			OP_REPEL:   cmd_in.op = OP_REPEL;
			OP_ATTRACT: cmd_in.op = OP_ATTRACT;
			OP_DAMP:    cmd_in.op = OP_DAMP;
			OP_UPDATE:  cmd_in.op = OP_UPDATE;
			default:    cmd_in.op = OP_NONE;
		endcase
	end

	// command queue toward the execution side
	pfi_fifo #(
		.W    ($bits(cmd_t)),
		.DEPTH(DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_data(cmd_in),
		.rd_en  (cmd_pop),
		.rd_data(cmd),
		.full   (full),
		.empty  (cmd_empty)
	);

	assign cmd_valid = !cmd_empty;

endmodule

// File: rtl/pfi_div.sv
module pfi_div (
	input  logic              clk,
	input  logic              arst_n,
	input  pfi_pkg::div_req_t req,
	output logic              done,
	output logic [63:0]       quo
);
	import pfi_pkg::*;

	logic [63:0] num_q;
	logic [31:0] den_q;
	logic [31:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic        qbit;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, num_q[63]};
	assign qbit  = (trial >= {1'b0, den_q});
	assign done  = done_q;
	assign quo   = num_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? 32'(trial - {1'b0, den_q}) : trial[31:0];
			num_q <= {num_q[62:0], qbit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/pfi_exec.sv
module pfi_exec (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pfi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pfi_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          cmd_valid,
	input  pfi_pkg::cmd_t                 cmd,
	output logic                          cmd_pop,
	input  logic                          res_full,
	output logic                          res_push,
	output pfi_pkg::res_t                 res
);
	import pfi_pkg::*;

	typedef enum logic [21:0] {
		S_IDLE  = 22'h000001,
		S_DMP1  = 22'h000002,
		S_DMP2  = 22'h000004,
		S_DMP3  = 22'h000008,
		S_UPD1  = 22'h000010,
		S_UPD2  = 22'h000020,
		S_UPD3  = 22'h000040,
		S_UPD4  = 22'h000080,
		S_UPD5  = 22'h000100,
		S_UPD6  = 22'h000200,
		S_RCHK  = 22'h000400,
		S_RSQ   = 22'h000800,
		S_RSUM  = 22'h001000,
		S_RSQRT = 22'h002000,
		S_RLEN  = 22'h004000,
		S_RPCT  = 22'h008000,
		S_RPROD = 22'h010000,
		S_RQUO  = 22'h020000,
		S_RMLO  = 22'h040000,
		S_RMHI  = 22'h080000,
		S_RFIN  = 22'h100000,
		S_ACC   = 22'h200000
	} state_t;

	localparam state_t S_EMIT_ALIAS = S_IDLE;

	state_t state_q;
	logic   emit_q;

	logic [CFG_W-1:0] damp_q, wall_w_q, wall_h_q;

	logic signed [DATA_W-1:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q, af_x_q, af_y_q;
	logic signed [DATA_W-1:0] df_x_q, df_y_q;
	logic                     hit_q;
	cmd_t                     cmd_q;
	logic signed [DATA_W:0]   dx_q, dy_q;
	logic [63:0]              sum_q, n_q, r_q;
	logic [62:0]              bit_q;
	logic [31:0]              len_q;
	logic [16:0]              pct_q;
	logic [63:0]              q_q, lp_q;
	logic                     comp_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p_q;

	logic [DATA_W:0]   dmx_w, dmy_w;
	logic [31:0]       dmx, dmy, smag;
	logic [REACH_W:0]  reach_w;
	logic [63:0]       sq_t;
	logic [63:0]       m64;
	logic              rneg;
	logic signed [DATA_W-1:0] rad, rad_f;
	logic [31:0]       bm;
	logic signed [DATA_W:0] maxv_x, maxv_y;

	div_req_t    dreq;
	logic        ddone;
	logic [63:0] dquo;

	pfi_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (dreq),
		.done  (ddone),
		.quo   (dquo)
	);

	// magnitudes of the difference vector and strength
	assign dmx_w   = dx_q[DATA_W] ? (~dx_q + 1'b1) : dx_q;
	assign dmy_w   = dy_q[DATA_W] ? (~dy_q + 1'b1) : dy_q;
	assign dmx     = dmx_w[31:0];
	assign dmy     = dmy_w[31:0];
	assign smag    = mag32(cmd_q.strength);
	assign reach_w = {1'b0, cmd_q.reach};
	assign sq_t    = r_q + {1'b0, bit_q};

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			S_DMP1:  begin mul_a = mag32(vel_x_q); mul_b = {16'b0, damp_q}; end
			S_DMP2:  begin mul_a = mag32(vel_y_q); mul_b = {16'b0, damp_q}; end
			S_UPD4:  begin mul_a = mag32(vel_x_q); mul_b = {16'b0, BOUNCE_GAIN}; end
			S_UPD5:  begin mul_a = mag32(vel_y_q); mul_b = {16'b0, BOUNCE_GAIN}; end
			S_RCHK:  begin mul_a = dmx; mul_b = dmx; end
			S_RSQ:   begin mul_a = dmy; mul_b = dmy; end
			S_RPCT:  begin mul_a = dmx; mul_b = smag; end
			S_RFIN:  begin mul_a = dmy; mul_b = smag; end
			S_RMLO:  begin mul_a = q_q[31:0]; mul_b = {15'b0, pct_q}; end
			S_RMHI:  begin mul_a = q_q[63:32]; mul_b = {15'b0, pct_q}; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_p_q <= mul_a * mul_b;
	end

	// radial force component from the two partial products
	always_comb begin
		m64  = {mul_p_q[47:0], 16'b0} + {16'b0, lp_q[63:16]};
		rneg = (comp_q ? dy_q[DATA_W] : dx_q[DATA_W]) ^ cmd_q.strength[DATA_W-1];
		if (m64 >= 64'h8000_0000) begin
			rad = rneg ? S32_MIN : S32_MAX;
		end else begin
			rad = rneg ? -$signed(m64[31:0]) : $signed(m64[31:0]);
		end
		rad_f = (cmd_q.op == OP_ATTRACT) ? neg32(rad) : rad;
	end

	// bounce and damping product, q0.16 scaled
	assign bm     = mul_p_q[47:16];
	assign maxv_x = $signed({1'b0, wall_w_q, 16'b0});
	assign maxv_y = $signed({1'b0, wall_h_q, 16'b0});

	// divider requests
	always_comb begin
		dreq.start = 1'b0;
		dreq.num   = '0;
		dreq.den   = '0;
		case (state_q)
			S_RLEN: begin
				dreq.start = (r_q != '0) && (r_q <= {33'b0, cmd_q.reach});
				dreq.num   = {17'b0, 31'(cmd_q.reach - r_q[30:0]), 16'b0};
				dreq.den   = {1'b0, cmd_q.reach};
			end
			S_RPROD: begin
				dreq.start = 1'b1;
				dreq.num   = mul_p_q;
				dreq.den   = len_q;
			end
			default: begin
				dreq.start = 1'b0;
			end
		endcase
	end

	assign cmd_pop  = (state_q == S_IDLE) && !emit_q && cmd_valid;
	assign res_push = emit_q && !res_full;

	always_comb begin
		res.px  = pos_x_q;
		res.py  = pos_y_q;
		res.vx  = vel_x_q;
		res.vy  = vel_y_q;
		res.dfx = df_x_q;
		res.dfy = df_y_q;
		res.hit = hit_q;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			damp_q   <= DAMP_RESET;
			wall_w_q <= WALL_W_RESET;
			wall_h_q <= WALL_H_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DAMP:   damp_q   <= cfg_data;
				REG_WALL_W: wall_w_q <= cfg_data;
				REG_WALL_H: wall_h_q <= cfg_data;
				default:    damp_q   <= damp_q;
			endcase
		end
	end

	// working registers of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd_pop) begin
					cmd_q  <= cmd;
					df_x_q <= (cmd.op == OP_ADD) ? cmd.ax : '0;
					df_y_q <= (cmd.op == OP_ADD) ? cmd.ay : '0;
					hit_q  <= 1'b0;
					dx_q   <= {pos_x_q[DATA_W-1], pos_x_q} - {cmd.ax[DATA_W-1], cmd.ax};
					dy_q   <= {pos_y_q[DATA_W-1], pos_y_q} - {cmd.ay[DATA_W-1], cmd.ay};
					comp_q <= 1'b0;
				end
			end
			S_DMP2: df_x_q <= vel_x_q[DATA_W-1] ? $signed(bm) : -$signed(bm);
			S_DMP3: df_y_q <= vel_y_q[DATA_W-1] ? $signed(bm) : -$signed(bm);
			S_RSQ:  sum_q <= mul_p_q;
			S_RSUM: begin
				n_q   <= sum_q + mul_p_q;
				r_q   <= '0;
				bit_q <= {1'b1, 62'b0};
			end
			S_RSQRT: begin
				if (n_q >= sq_t) begin
					n_q <= n_q - sq_t;
					r_q <= (r_q >> 1) + {1'b0, bit_q};
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_RLEN: len_q <= r_q[31:0];
			S_RPCT: if (ddone) pct_q <= dquo[16:0];
			S_RQUO: if (ddone) q_q <= dquo;
			S_RMHI: lp_q <= mul_p_q;
			S_RFIN: begin
				if (comp_q) begin
					df_y_q <= rad_f;
				end else begin
					df_x_q <= rad_f;
					comp_q <= 1'b1;
				end
			end
			S_UPD3: hit_q <= ($signed({pos_x_q[DATA_W-1], pos_x_q}) > maxv_x) ||
					pos_x_q[DATA_W-1] ||
					($signed({pos_y_q[DATA_W-1], pos_y_q}) > maxv_y) ||
					pos_y_q[DATA_W-1];
			default: cmd_q <= cmd_q;
		endcase
	end

	// particle state and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			emit_q  <= 1'b0;
			pos_x_q <= '0;
			pos_y_q <= '0;
			vel_x_q <= '0;
			vel_y_q <= '0;
			af_x_q  <= '0;
			af_y_q  <= '0;
		end else begin
			if (res_push) begin
				emit_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_pop) begin
						case (cmd.op)
							OP_LOAD: begin
								pos_x_q <= cmd.ax;
								pos_y_q <= cmd.ay;
								vel_x_q <= cmd.lvx;
								vel_y_q <= cmd.lvy;
								emit_q  <= 1'b1;
							end
							OP_CLEAR: begin
								af_x_q <= '0;
								af_y_q <= '0;
								emit_q <= 1'b1;
							end
							OP_ADD:     state_q <= S_ACC;
							OP_REPEL:   state_q <= S_RCHK;
							OP_ATTRACT: state_q <= S_RCHK;
							OP_DAMP:    state_q <= S_DMP1;
							OP_UPDATE:  state_q <= S_UPD1;
							default:    emit_q  <= 1'b1;
						endcase
					end
				end
				S_DMP1: state_q <= S_DMP2;
				S_DMP2: state_q <= S_DMP3;
				S_DMP3: state_q <= S_ACC;
				S_UPD1: begin
					vel_x_q <= sat33({vel_x_q[DATA_W-1], vel_x_q} + {af_x_q[DATA_W-1], af_x_q});
					vel_y_q <= sat33({vel_y_q[DATA_W-1], vel_y_q} + {af_y_q[DATA_W-1], af_y_q});
					state_q <= S_UPD2;
				end
				S_UPD2: begin
					pos_x_q <= sat33({pos_x_q[DATA_W-1], pos_x_q} + {vel_x_q[DATA_W-1], vel_x_q});
					pos_y_q <= sat33({pos_y_q[DATA_W-1], pos_y_q} + {vel_y_q[DATA_W-1], vel_y_q});
					state_q <= S_UPD3;
				end
				S_UPD3: begin
					// clamp each axis at its walls and reflect the velocity
					if ($signed({pos_x_q[DATA_W-1], pos_x_q}) > maxv_x) begin
						pos_x_q <= maxv_x[DATA_W-1:0];
						vel_x_q <= neg32(vel_x_q);
					end else if (pos_x_q[DATA_W-1]) begin
						pos_x_q <= '0;
						vel_x_q <= neg32(vel_x_q);
					end
					if ($signed({pos_y_q[DATA_W-1], pos_y_q}) > maxv_y) begin
						pos_y_q <= maxv_y[DATA_W-1:0];
						vel_y_q <= neg32(vel_y_q);
					end else if (pos_y_q[DATA_W-1]) begin
						pos_y_q <= '0;
						vel_y_q <= neg32(vel_y_q);
					end
					if (($signed({pos_x_q[DATA_W-1], pos_x_q}) > maxv_x) ||
							pos_x_q[DATA_W-1] ||
							($signed({pos_y_q[DATA_W-1], pos_y_q}) > maxv_y) ||
							pos_y_q[DATA_W-1]) begin
						state_q <= S_UPD4;
					end else begin
						state_q <= S_EMIT_ALIAS;
						emit_q  <= 1'b1;
					end
				end
				S_UPD4: state_q <= S_UPD5;
				S_UPD5: begin
					vel_x_q <= vel_x_q[DATA_W-1] ? -$signed(bm) : $signed(bm);
					state_q <= S_UPD6;
				end
				S_UPD6: begin
					vel_y_q <= vel_y_q[DATA_W-1] ? -$signed(bm) : $signed(bm);
					state_q <= S_IDLE;
					emit_q  <= 1'b1;
				end
				S_RCHK: begin
					if (cmd_q.reach == '0 || dmx_w > {1'b0, reach_w} || dmy_w > {1'b0, reach_w}) begin
						state_q <= S_ACC;
					end else begin
						state_q <= S_RSQ;
					end
				end
				S_RSQ:   state_q <= S_RSUM;
				S_RSUM:  state_q <= S_RSQRT;
				S_RSQRT: if (bit_q[0]) state_q <= S_RLEN;
				S_RLEN:  state_q <= dreq.start ? S_RPCT : S_ACC;
				S_RPCT:  if (ddone) state_q <= S_RPROD;
				S_RPROD: state_q <= S_RQUO;
				S_RQUO:  if (ddone) state_q <= S_RMLO;
				S_RMLO:  state_q <= S_RMHI;
				S_RMHI:  state_q <= S_RFIN;
				S_RFIN:  state_q <= comp_q ? S_ACC : S_RPROD;
				S_ACC: begin
					af_x_q  <= sat33({af_x_q[DATA_W-1], af_x_q} + {df_x_q[DATA_W-1], df_x_q});
					af_y_q  <= sat33({af_y_q[DATA_W-1], af_y_q} + {df_y_q[DATA_W-1], df_y_q});
					state_q <= S_IDLE;
					emit_q  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/particle_force_integrator_unit.sv
// particle force integrator: one 2d particle in signed q16.16
// input channel: drive the item fields with push high; the item is taken on
// a rising edge with push high and full low. a small command queue sits in
// front of the sequencer, so items may be pushed while earlier ones run.
// result channel: while empty is low the oldest result is on the result
// ports; it is taken on a rising edge with pop high. a result queue holds
// finished items, and the sequencer waits only when that queue is full.
// configuration: cfg_we with cfg_index 0 damping, 1 wall width, 2 wall
// height; write only while the block holds no item.
// repel and attract run a 32-step square root and three 64-step
// divisions in the shared divider.
// items are executed one at a time in order, one result each.
// reset clears the particle state and force and loads the register defaults;
// both queues come up empty.
module particle_force_integrator_unit #(
	parameter int CMD_DEPTH = pfi_pkg::CMD_DEPTH,
	parameter int RES_DEPTH = pfi_pkg::RES_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [pfi_pkg::KIND_W-1:0]        kind,
	input  logic signed [pfi_pkg::DATA_W-1:0] arg_x,
	input  logic signed [pfi_pkg::DATA_W-1:0] arg_y,
	input  logic signed [pfi_pkg::DATA_W-1:0] load_vel_x,
	input  logic signed [pfi_pkg::DATA_W-1:0] load_vel_y,
	input  logic [pfi_pkg::REACH_W-1:0]       reach,
	input  logic signed [pfi_pkg::DATA_W-1:0] strength,
	output logic                              empty,
	input  logic                              pop,
	output logic signed [pfi_pkg::DATA_W-1:0] pos_x_out,
	output logic signed [pfi_pkg::DATA_W-1:0] pos_y_out,
	output logic signed [pfi_pkg::DATA_W-1:0] vel_x_out,
	output logic signed [pfi_pkg::DATA_W-1:0] vel_y_out,
	output logic signed [pfi_pkg::DATA_W-1:0] delta_fx,
	output logic signed [pfi_pkg::DATA_W-1:0] delta_fy,
	output logic                              hit_wall,
	input  logic                              cfg_we,
	input  logic [pfi_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pfi_pkg::CFG_W-1:0]         cfg_data
);
	import pfi_pkg::*;

	logic cmd_valid, cmd_pop, res_full, res_push;
	cmd_t cmd;
	res_t res_in, res_out;

	// front: classify and queue items
	pfi_front #(
		.DEPTH(CMD_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.kind      (kind),
		.arg_x     (arg_x),
		.arg_y     (arg_y),
		.load_vel_x(load_vel_x),
		.load_vel_y(load_vel_y),
		.reach     (reach),
		.strength  (strength),
		.cmd_pop   (cmd_pop),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	// back: sequencer with shared multiplier, divider and root
	pfi_exec u_exec (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	// result queue
	pfi_fifo #(
		.W    ($bits(res_t)),
		.DEPTH(RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res_in),
		.rd_en  (pop),
		.rd_data(res_out),
		.full   (res_full),
		.empty  (empty)
	);

	assign pos_x_out = res_out.px;
	assign pos_y_out = res_out.py;
	assign vel_x_out = res_out.vx;
	assign vel_y_out = res_out.vy;
	assign delta_fx  = res_out.dfx;
	assign delta_fy  = res_out.dfy;
	assign hit_wall  = res_out.hit;

endmodule

// File: tb/sv/pfi_checker.sv
module pfi_checker
	import pfi_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic                     full,
	input  logic [KIND_W-1:0]        kind,
	input  logic signed [DATA_W-1:0] arg_x,
	input  logic signed [DATA_W-1:0] arg_y,
	input  logic signed [DATA_W-1:0] load_vel_x,
	input  logic signed [DATA_W-1:0] load_vel_y,
	input  logic [REACH_W-1:0]       reach,
	input  logic signed [DATA_W-1:0] strength,
	input  logic                     empty,
	input  logic                     pop,
	input  logic signed [DATA_W-1:0] pos_x_out,
	input  logic signed [DATA_W-1:0] pos_y_out,
	input  logic signed [DATA_W-1:0] vel_x_out,
	input  logic signed [DATA_W-1:0] vel_y_out,
	input  logic signed [DATA_W-1:0] delta_fx,
	input  logic signed [DATA_W-1:0] delta_fy,
	input  logic                     hit_wall,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	output int                       errors,
	output int                       pending,
	output logic signed [DATA_W-1:0] track_px,
	output logic signed [DATA_W-1:0] track_py
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint MAX_L = 64'sd2147483647;
	localparam longint MIN_L = -64'sd2147483648;

	// particle model and register copies
	longint px, py, vx, vy, fx, fy;
	logic [CFG_W-1:0] damp_gain, wall_w, wall_h;
	res_t expected_q[$];

	function automatic longint clip32(input longint v);
		if (v > MAX_L) return MAX_L;
		if (v < MIN_L) return MIN_L;
		return v;
	endfunction

	function automatic longint absl(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint root64(input longint n_in);
		longint unsigned n, r, b;
		n = n_in;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return longint'(r);
	endfunction

	// signed value times unsigned q0.16 gain, truncated toward zero
	function automatic longint gain_mul(input longint v, input longint g);
		longint m;
		m = (absl(v) * g) >>> 16;
		return v < 0 ? -m : m;
	endfunction

	function automatic longint radial_part(input longint d, input longint s,
			input longint len, input longint pct);
		longint q, m;
		q = (absl(d) * absl(s)) / len;
		m = (q * pct) >>> 16;
		return clip32(((d < 0) != (s < 0)) ? -m : m);
	endfunction

	// one event applied to the model, returns the result it should give
	function automatic res_t apply_event(input op_t op, input longint ax, input longint ay,
			input longint lvx, input longint lvy, input longint rch, input longint str);
		res_t r;
		longint dfx, dfy, dx, dy, len, pct;
		logic hx, hy;
		dfx = 0;
		dfy = 0;
		hx = 0;
		hy = 0;
		case (op)
			OP_LOAD: begin
				px = ax; py = ay; vx = lvx; vy = lvy;
			end
			OP_CLEAR: begin
				fx = 0; fy = 0;
			end
			OP_ADD: begin
				dfx = ax; dfy = ay;
			end
			OP_REPEL, OP_ATTRACT: begin
				dx = px - ax;
				dy = py - ay;
				if (rch != 0 && absl(dx) <= rch && absl(dy) <= rch) begin
					len = root64(dx * dx + dy * dy);
					if (len != 0 && len <= rch) begin
						pct = ((rch - len) << 16) / rch;
						dfx = radial_part(dx, str, len, pct);
						dfy = radial_part(dy, str, len, pct);
						if (op == OP_ATTRACT) begin
							dfx = clip32(-dfx);
							dfy = clip32(-dfy);
						end
					end
				end
			end
			OP_DAMP: begin
				dfx = -gain_mul(vx, damp_gain);
				dfy = -gain_mul(vy, damp_gain);
			end
			OP_UPDATE: begin
				vx = clip32(vx + fx);
				vy = clip32(vy + fy);
				px = clip32(px + vx);
				py = clip32(py + vy);
				// wall clamp per axis, bounce negates the component
				if (px > longint'(wall_w) * 65536) begin
					px = longint'(wall_w) * 65536; vx = clip32(-vx); hx = 1;
				end else if (px < 0) begin
					px = 0; vx = clip32(-vx); hx = 1;
				end
				if (py > longint'(wall_h) * 65536) begin
					py = longint'(wall_h) * 65536; vy = clip32(-vy); hy = 1;
				end else if (py < 0) begin
					py = 0; vy = clip32(-vy); hy = 1;
				end
				if (hx || hy) begin
					vx = gain_mul(vx, BOUNCE_GAIN);
					vy = gain_mul(vy, BOUNCE_GAIN);
				end
			end
			default: begin
			end
		endcase
		if (op inside {OP_ADD, OP_REPEL, OP_ATTRACT, OP_DAMP}) begin
			fx = clip32(fx + dfx);
			fy = clip32(fy + dfy);
		end
		r.px = px[31:0];
		r.py = py[31:0];
		r.vx = vx[31:0];
		r.vy = vy[31:0];
		r.dfx = dfx[31:0];
		r.dfy = dfy[31:0];
		r.hit = hx || hy;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			px = 0; py = 0; vx = 0; vy = 0; fx = 0; fy = 0;
			damp_gain = DAMP_RESET;
			wall_w = WALL_W_RESET;
			wall_h = WALL_H_RESET;
			expected_q.delete();
			errors <= 0;
			pending <= 0;
			track_px <= '0;
			track_py <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DAMP:   damp_gain = cfg_data;
					REG_WALL_W: wall_w = cfg_data;
					REG_WALL_H: wall_h = cfg_data;
					default: ;
				endcase
			end
			if (push && !full) begin
				expected_q.push_back(apply_event(op_t'(kind), longint'(arg_x),
					longint'(arg_y), longint'(load_vel_x), longint'(load_vel_y),
					longint'({1'b0, reach}), longint'(strength)));
			end
			if (pop && !empty) begin
				if (expected_q.size() == 0) begin
					$error("result item with no expected item waiting");
					errors++;
				end else begin
					want = expected_q.pop_front();
					check_field("pos_x_out", want.px, pos_x_out);
					check_field("pos_y_out", want.py, pos_y_out);
					check_field("vel_x_out", want.vx, vel_x_out);
					check_field("vel_y_out", want.vy, vel_y_out);
					check_field("delta_fx", want.dfx, delta_fx);
					check_field("delta_fy", want.dfy, delta_fy);
					check_field("hit_wall", want.hit, hit_wall);
				end
			end
			pending <= expected_q.size();
			track_px <= px[31:0];
			track_py <= py[31:0];
		end
	end

	final begin
		if (expected_q.size() != 0) begin
			$error("%0d expected items never came out", expected_q.size());
		end
	end

endmodule

// File: tb/sv/testbench.sv
module testbench;
	import pfi_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int ITEMS_PER_PHASE = 177;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int STALL_LIMIT = 3000;
	localparam logic signed [31:0] ONE = 32'sd65536;

	logic clk, arst_n;
	logic push, full, empty, pop;
	logic [KIND_W-1:0] kind;
	logic signed [DATA_W-1:0] arg_x, arg_y, load_vel_x, load_vel_y, strength;
	logic [REACH_W-1:0] reach;
	logic signed [DATA_W-1:0] pos_x_out, pos_y_out, vel_x_out, vel_y_out;
	logic signed [DATA_W-1:0] delta_fx, delta_fy;
	logic hit_wall;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	int errors, pending;
	logic signed [DATA_W-1:0] track_px, track_py;

	int send_idle, recv_idle, stall_cnt;
	bit hold_req;
	int wall_w_now, wall_h_now;

	particle_force_integrator_unit dut (.*);

	pfi_checker u_checker (.*);

	// clock
	initial clk = 0;
	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// watchdog on cycles with no accepted item on either side
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			stall_cnt <= 0;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
		if (stall_cnt >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// result side: random pop, with one long hold-off on request
	initial begin
		pop = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				pop <= 0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			pop <= ($urandom_range(99) >= recv_idle);
		end
	end

	function automatic logic signed [31:0] near(input int span);
		return $signed($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic logic signed [31:0] any_val(input int span);
		case ($urandom_range(9))
			0, 1: return $urandom;
			2: return S32_MAX;
			3: return S32_MIN;
			default: return near(span);
		endcase
	endfunction

	function automatic logic signed [31:0] clip_add(input logic signed [31:0] a,
			input logic signed [31:0] b);
		longint s;
		s = longint'(a) + longint'(b);
		if (s > longint'(S32_MAX)) return S32_MAX;
		if (s < longint'(S32_MIN)) return S32_MIN;
		return s[31:0];
	endfunction

	// offer one item, return at the edge that takes it
	task automatic send(input op_t op, input logic signed [31:0] ax, input logic signed [31:0] ay,
			input logic signed [31:0] lvx, input logic signed [31:0] lvy,
			input logic [30:0] rch, input logic signed [31:0] str);
		while ($urandom_range(99) < send_idle) begin
			push <= 0;
			@(posedge clk);
		end
		push <= 1;
		kind <= op;
		arg_x <= ax;
		arg_y <= ay;
		load_vel_x <= lvx;
		load_vel_y <= lvy;
		reach <= rch;
		strength <= str;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic drain();
		push <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic set_regs(input int damp, input int ww, input int wh);
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1;
		cfg_index <= REG_DAMP;
		cfg_data <= CFG_W'(damp);
		@(posedge clk);
		cfg_index <= REG_WALL_W;
		cfg_data <= CFG_W'(ww);
		@(posedge clk);
		cfg_index <= REG_WALL_H;
		cfg_data <= CFG_W'(wh);
		@(posedge clk);
		// spare index must be ignored
		cfg_index <= REG_SPARE;
		cfg_data <= CFG_W'($urandom);
		@(posedge clk);
		cfg_we <= 0;
		wall_w_now = ww;
		wall_h_now = wh;
	endtask

	// one random item; repel and attract are shaped around the particle's position
	task automatic random_item();
		op_t op;
		int r, rc;
		logic signed [31:0] ax, ay, lvx, lvy, str;
		logic [30:0] rch;
		ax = $urandom;
		ay = $urandom;
		lvx = $urandom;
		lvy = $urandom;
		rch = 31'($urandom);
		str = $urandom;
		r = $urandom_range(99);
		if (r < 8) begin
			op = op_t'($urandom_range(7));
		end else begin
			if (r < 18) op = OP_LOAD;
			else if (r < 23) op = OP_CLEAR;
			else if (r < 37) op = OP_ADD;
			else if (r < 55) op = OP_REPEL;
			else if (r < 70) op = OP_ATTRACT;
			else if (r < 79) op = OP_DAMP;
			else if (r < 97) op = OP_UPDATE;
			else op = OP_NONE;
			case (op)
				OP_LOAD: begin
					ax = 32'((longint'($urandom_range(0, wall_w_now)) << 16)
						| $urandom_range(0, 65535));
					ay = 32'((longint'($urandom_range(0, wall_h_now)) << 16)
						| $urandom_range(0, 65535));
					lvx = any_val(8 * ONE);
					lvy = any_val(8 * ONE);
				end
				OP_ADD: begin
					ax = any_val(2 * ONE);
					ay = any_val(2 * ONE);
				end
				OP_REPEL, OP_ATTRACT: begin
					rc = $urandom_range(1, 64 * ONE);
					ax = clip_add(track_px, near(rc));
					ay = clip_add(track_py, near(rc));
					if ($urandom_range(9) == 0) rch = 0;
					else if ($urandom_range(9) != 0) rch = 31'(rc);
					str = any_val(16 * ONE);
				end
				default: ;
			endcase
		end
		send(op, ax, ay, lvx, lvy, rch, str);
	endtask

	// stimulus
	initial begin
		arst_n = 0;
		push = 0;
		kind = OP_NONE;
		arg_x = 0;
		arg_y = 0;
		load_vel_x = 0;
		load_vel_y = 0;
		reach = 0;
		strength = 0;
		cfg_we = 0;
		cfg_index = REG_DAMP;
		cfg_data = 0;
		hold_req = 0;
		send_idle = 36;
		recv_idle = 77;
		wall_w_now = WALL_W_RESET;
		wall_h_now = WALL_H_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed events at reset register values
		send(OP_LOAD, 0, 0, 0, 0, 0, 0);
		send(OP_ADD, S32_MAX, S32_MIN, 0, 0, 0, 0);
		send(OP_ADD, S32_MAX, S32_MIN, 0, 0, 0, 0);
		send(OP_CLEAR, 0, 0, 0, 0, 0, 0);
		send(OP_LOAD, 100 * ONE, 50 * ONE, 3 * ONE, -2 * ONE, 0, 0);
		send(OP_REPEL, 90 * ONE, 50 * ONE, 0, 0, 20 * ONE, 5 * ONE);
		send(OP_ATTRACT, 95 * ONE, 47 * ONE, 0, 0, 20 * ONE, -7 * ONE);
		// zero reach, outside reach, zero length
		send(OP_REPEL, 99 * ONE, 50 * ONE, 0, 0, 0, 5 * ONE);
		send(OP_REPEL, 10 * ONE, 50 * ONE, 0, 0, 20 * ONE, 5 * ONE);
		send(OP_ATTRACT, 100 * ONE, 50 * ONE, 0, 0, 20 * ONE, 5 * ONE);
		send(OP_DAMP, 0, 0, 0, 0, 0, 0);
		send(OP_UPDATE, 0, 0, 0, 0, 0, 0);
		send(OP_LOAD, 1023 * ONE, ONE, S32_MAX, S32_MIN, 0, 0);
		send(OP_UPDATE, 0, 0, 0, 0, 0, 0);
		send(OP_NONE, S32_MAX, S32_MIN, S32_MAX, S32_MIN, '1, S32_MIN);
		send(OP_LOAD, S32_MIN, S32_MAX, S32_MIN, S32_MAX, 0, 0);
		send(OP_DAMP, 0, 0, 0, 0, 0, 0);
		send(OP_UPDATE, 0, 0, 0, 0, 0, 0);
		send(OP_REPEL, 1 * ONE, 1 * ONE, 0, 0, '1, S32_MIN);
		send(OP_ATTRACT, -5 * ONE, 3 * ONE, 0, 0, '1, S32_MAX);
		send(OP_UPDATE, 0, 0, 0, 0, 0, 0);
		send(OP_CLEAR, 0, 0, 0, 0, 0, 0);

		// random phases over several register settings
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: set_regs(0, 65535, 1);
				1: set_regs(65535, 1, 65535);
				default: set_regs(30000, 0, 200);
			endcase
			send_idle = (ph == 0) ? 36 : (ph == 1) ? 77 : 0;
			recv_idle = (ph == 0) ? 77 : (ph == 1) ? 36 : 0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == 0 && n == 90) drain();
				if (ph == 2 && n == 40) hold_req = 1;
				random_item();
			end
		end
		set_regs(DAMP_RESET, WALL_W_RESET, WALL_H_RESET);
		for (int n = 0; n < 20; n++) random_item();

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/pfi_pkg.sv
rtl/pfi_fifo.sv
rtl/pfi_front.sv
rtl/pfi_div.sv
rtl/pfi_exec.sv
rtl/particle_force_integrator_unit.sv
tb/sv/pfi_checker.sv
tb/sv/testbench.sv
